/* rtl/core/cdmf_pkg.sv */
// Shared types and constants of the multi-filter valid convolution block.
package cdmf_pkg;

    // Item opcodes on the input side.
    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam int REG_ADDR_W = 2;
    localparam logic [REG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam int DIM_W = 11;
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd128;

    // Frame height limit and fixed field widths.
    localparam int MAX_HEIGHT = 1024;
    localparam int POS_W      = 10;
    localparam int FIDX_W     = 3;
    localparam int TAP_W      = 6;
    localparam int COEF_W     = 32;
    localparam int WGT_W      = 16;
    localparam int PIX_W      = 8;
    localparam int PROD_W     = 25;

    // Queue depths between the stages.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Kind of work the back end carries out for one queued job.
    typedef enum logic [1:0] {
        JOB_WEIGHT = 2'd0,
        JOB_BIAS   = 2'd1,
        JOB_WINDOW = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [FIDX_W-1:0]  filter;
        logic [TAP_W-1:0]   tap;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               frame_end;
    } t_job_ctl;

    typedef struct packed {
        logic [FIDX_W-1:0]        out_filter;
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic signed [COEF_W-1:0] feature_value;
        logic                     last_of_position;
        logic                     end_of_frame;
    } t_result;

endpackage

/* rtl/core/cdmf_ram.sv */
// Generic single-write, single-read memory with registered read data.
module cdmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cdmf_queue.sv */
// Small register queue with an occupancy count, used between stages.
module cdmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // A push into a full queue would overwrite an entry still waiting.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)) || i_pop)
        else $error("queue pushed while full");

    // A pop from an empty queue would replay a stale entry.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

/* rtl/core/cdmf_front.sv */
// Front end: item intake, frame counters, line store and window shift.
module cdmf_front #(
    parameter int KERNEL    = 3,
    parameter int FILTERS   = 8,
    parameter int MAX_WIDTH = 1024,
    parameter int QDEPTH    = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cdmf_pkg::REG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [cdmf_pkg::DIM_W-1:0]             i_cfg_wdata,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [1:0]                             i_op,
    input  logic [cdmf_pkg::FIDX_W-1:0]            i_filter_index,
    input  logic [cdmf_pkg::TAP_W-1:0]             i_tap_index,
    input  logic [cdmf_pkg::COEF_W-1:0]            i_coefficient,
    input  logic [cdmf_pkg::PIX_W-1:0]             i_pixel,
    input  logic [$clog2(QDEPTH+1)-1:0]            i_q_count,
    output logic                                   o_q_push,
    output cdmf_pkg::t_job_ctl                     o_q_ctl,
    output logic [cdmf_pkg::COEF_W-1:0]            o_q_coef,
    output logic [KERNEL*KERNEL*cdmf_pkg::PIX_W-1:0] o_q_window
);

    localparam int TAPS  = KERNEL * KERNEL;
    localparam int LINES = (KERNEL > 1) ? (KERNEL - 1) : 1;
    localparam int PW    = cdmf_pkg::PIX_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WW > cdmf_pkg::DIM_W) ? WW : cdmf_pkg::DIM_W;
    localparam int QCW   = $clog2(QDEPTH + 1);
    localparam int RW    = cdmf_pkg::POS_W;
    localparam int DW    = cdmf_pkg::DIM_W;

    logic [DW-1:0]   r_image_width;
    logic [DW-1:0]   r_image_height;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;

    logic [CMPW-1:0] w_use;
    logic [DW-1:0]   h_use;
    logic [CMPW-1:0] col_next;
    logic [DW-1:0]   row_next;
    logic            accept;
    logic            is_pixel;
    logic            load_ok;
    logic            emit;

    // Stage 1 registers: the line store read data lines up with these.
    logic                     r_s1_valid;
    logic                     r_s1_emit;
    cdmf_pkg::t_job_ctl       r_s1_ctl;
    logic [cdmf_pkg::COEF_W-1:0] r_s1_coef;
    logic [PW-1:0]            r_s1_pixel;
    logic [CW-1:0]            r_s1_addr;

    logic [PW-1:0]            r_win [TAPS];
    logic [PW-1:0]            n_win [TAPS];
    logic [PW-1:0]            column [KERNEL];
    logic [LINES*PW-1:0]      line_rdata;
    logic [LINES*PW-1:0]      line_wdata;
    logic                     line_we;

    // Dimensions in use are the registers saturated to the legal range.
    always_comb begin
        if (CMPW'(r_image_width) < CMPW'(KERNEL)) begin
            w_use = CMPW'(KERNEL);
        end else if (CMPW'(r_image_width) > CMPW'(MAX_WIDTH)) begin
            w_use = CMPW'(MAX_WIDTH);
        end else begin
            w_use = CMPW'(r_image_width);
        end
        if (r_image_height < DW'(KERNEL)) begin
            h_use = DW'(KERNEL);
        end else if (r_image_height > DW'(cdmf_pkg::MAX_HEIGHT)) begin
            h_use = DW'(cdmf_pkg::MAX_HEIGHT);
        end else begin
            h_use = r_image_height;
        end
    end

    assign col_next = CMPW'(r_col) + CMPW'(1);
    assign row_next = DW'(r_row) + DW'(1);
    assign accept   = i_push && !o_full;
    assign is_pixel = (i_op == cdmf_pkg::OP_PIXEL);
    assign emit     = (r_row >= RW'(KERNEL - 1)) && (CMPW'(r_col) >= CMPW'(KERNEL - 1));

    always_comb begin
        load_ok = 1'b0;
        unique case (i_op)
            cdmf_pkg::OP_WEIGHT: begin
                load_ok = ({2'b00, i_filter_index} < 5'(FILTERS))
                       && (i_tap_index < cdmf_pkg::TAP_W'(TAPS));
            end
            cdmf_pkg::OP_BIAS: begin
                load_ok = ({2'b00, i_filter_index} < 5'(FILTERS));
            end
            default: begin
                load_ok = 1'b0;
            end
        endcase
    end

    // A slot is reserved for the item in stage 1 as well as those queued.
    assign o_full = !i_rst_n
        || (({1'b0, i_q_count} + (QCW+1)'(r_s1_valid)) >= (QCW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= cdmf_pkg::DIM_RESET;
            r_image_height <= cdmf_pkg::DIM_RESET;
            r_row          <= '0;
            r_col          <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == cdmf_pkg::REG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_wdata;
                r_row         <= '0;
                r_col         <= '0;
            end else if (i_cfg_addr == cdmf_pkg::REG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_wdata;
                r_row          <= '0;
                r_col          <= '0;
            end
        end else if (accept && is_pixel) begin
            if (col_next >= w_use) begin
                r_col <= '0;
                r_row <= (row_next >= h_use) ? '0 : RW'(row_next);
            end else begin
                r_col <= CW'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && (is_pixel || load_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (i_op)
                cdmf_pkg::OP_WEIGHT: r_s1_ctl.kind <= cdmf_pkg::JOB_WEIGHT;
                cdmf_pkg::OP_BIAS:   r_s1_ctl.kind <= cdmf_pkg::JOB_BIAS;
                default:             r_s1_ctl.kind <= cdmf_pkg::JOB_WINDOW;
            endcase
            r_s1_ctl.filter    <= i_filter_index;
            r_s1_ctl.tap       <= i_tap_index;
            r_s1_ctl.row       <= r_row - RW'(KERNEL - 1);
            r_s1_ctl.col       <= RW'(r_col - CW'(KERNEL - 1));
            r_s1_ctl.frame_end <= (row_next == h_use) && (col_next == w_use);
            r_s1_emit          <= emit;
            r_s1_coef          <= i_coefficient;
            r_s1_pixel         <= i_pixel;
            r_s1_addr          <= r_col;
        end
    end

    cdmf_ram #(
        .WIDTH (LINES * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_s1_addr),
        .i_wdata (line_wdata),
        .i_raddr (r_col),
        .o_rdata (line_rdata)
    );

    // Line k of the store holds the pixel k+1 rows above the current one.
    always_comb begin
        for (int k = 0; k < KERNEL - 1; k++) begin
            column[k] = line_rdata[(KERNEL - 2 - k) * PW +: PW];
        end
        column[KERNEL - 1] = r_s1_pixel;
        line_wdata[PW-1:0] = r_s1_pixel;
        for (int k = 1; k < LINES; k++) begin
            line_wdata[k * PW +: PW] = line_rdata[(k - 1) * PW +: PW];
        end
        for (int i = 0; i < KERNEL; i++) begin
            for (int j = 0; j < KERNEL - 1; j++) begin
                n_win[i * KERNEL + j] = r_win[i * KERNEL + j + 1];
            end
            n_win[i * KERNEL + KERNEL - 1] = column[i];
        end
        for (int t = 0; t < TAPS; t++) begin
            o_q_window[t * PW +: PW] = n_win[t];
        end
    end

    assign line_we = r_s1_valid && (r_s1_ctl.kind == cdmf_pkg::JOB_WINDOW);

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            for (int t = 0; t < TAPS; t++) begin
                r_win[t] <= n_win[t];
            end
        end
    end

    assign o_q_push = r_s1_valid && ((r_s1_ctl.kind != cdmf_pkg::JOB_WINDOW) || r_s1_emit);
    assign o_q_ctl  = r_s1_ctl;
    assign o_q_coef = r_s1_coef;

    // A dimension write restarts the frame at its first pixel.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_addr == cdmf_pkg::REG_IMAGE_WIDTH
                  || i_cfg_addr == cdmf_pkg::REG_IMAGE_HEIGHT)
        |=> r_row == '0 && r_col == '0)
        else $error("frame counters not restarted by a dimension write");

endmodule

/* rtl/core/cdmf_back.sv */
// Back end: coefficient stores and the pipelined per-filter dot product.
module cdmf_back #(
    parameter int KERNEL  = 3,
    parameter int FILTERS = 8,
    parameter int ODEPTH  = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_q_empty,
    input  cdmf_pkg::t_job_ctl                       i_q_ctl,
    input  logic [cdmf_pkg::COEF_W-1:0]              i_q_coef,
    input  logic [KERNEL*KERNEL*cdmf_pkg::PIX_W-1:0] i_q_window,
    output logic                                     o_q_pop,
    input  logic [$clog2(ODEPTH+1)-1:0]              i_out_count,
    output logic                                     o_out_push,
    output cdmf_pkg::t_result                        o_out_data
);

    localparam int TAPS = KERNEL * KERNEL;
    localparam int FW   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int TW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int OCW  = $clog2(ODEPTH + 1);
    localparam int PW   = cdmf_pkg::PIX_W;
    localparam int PRW  = cdmf_pkg::PROD_W;
    localparam int SW   = cdmf_pkg::COEF_W;

    logic signed [cdmf_pkg::WGT_W-1:0] r_weight [TAPS][FILTERS];
    logic signed [SW-1:0]              r_bias [FILTERS];
    logic [FW-1:0]                     r_f;

    logic head_window;
    logic credit;
    logic issue;
    logic last_f;

    logic                  r_p1_valid;
    cdmf_pkg::t_result     r_p1_res;
    logic signed [PRW-1:0] r_p1_prod [TAPS];
    logic signed [SW-1:0]  r_p1_bias;

    logic                  r_p2_valid;
    cdmf_pkg::t_result     r_p2_res;
    logic signed [SW-1:0]  r_p2_rowsum [KERNEL];
    logic signed [SW-1:0]  r_p2_bias;
    logic signed [SW-1:0]  n_rowsum [KERNEL];
    logic signed [SW-1:0]  total;

    assign head_window = !i_q_empty && (i_q_ctl.kind == cdmf_pkg::JOB_WINDOW);
    assign credit = ({1'b0, i_out_count} + (OCW+1)'(r_p1_valid) + (OCW+1)'(r_p2_valid))
                    < (OCW+1)'(ODEPTH);
    assign issue  = head_window && credit;
    assign last_f = (r_f == FW'(FILTERS - 1));
    assign o_q_pop = !i_q_empty
        && ((i_q_ctl.kind != cdmf_pkg::JOB_WINDOW) || (issue && last_f));

    // Coefficient loads take effect in queue order, between windows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                for (int f = 0; f < FILTERS; f++) begin
                    r_weight[t][f] <= '0;
                end
            end
            for (int f = 0; f < FILTERS; f++) begin
                r_bias[f] <= '0;
            end
        end else if (!i_q_empty) begin
            if (i_q_ctl.kind == cdmf_pkg::JOB_WEIGHT) begin
                r_weight[TW'(i_q_ctl.tap)][FW'(i_q_ctl.filter)] <=
                    i_q_coef[cdmf_pkg::WGT_W-1:0];
            end else if (i_q_ctl.kind == cdmf_pkg::JOB_BIAS) begin
                r_bias[FW'(i_q_ctl.filter)] <= i_q_coef;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f        <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_f <= last_f ? '0 : r_f + FW'(1);
            end
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
        end
    end

    // Stage 1: one product per tap for the filter being issued.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            for (int t = 0; t < TAPS; t++) begin
                r_p1_prod[t] <= PRW'(r_weight[t][r_f])
                              * PRW'($signed({1'b0, i_q_window[t * PW +: PW]}));
            end
            r_p1_bias                 <= r_bias[r_f];
            r_p1_res.out_filter       <= cdmf_pkg::FIDX_W'(r_f);
            r_p1_res.out_row          <= i_q_ctl.row;
            r_p1_res.out_col          <= i_q_ctl.col;
            r_p1_res.feature_value    <= '0;
            r_p1_res.last_of_position <= last_f;
            r_p1_res.end_of_frame     <= last_f && i_q_ctl.frame_end;
        end
    end

    // Stage 2: sum each kernel row.
    always_comb begin
        for (int i = 0; i < KERNEL; i++) begin
            n_rowsum[i] = '0;
            for (int j = 0; j < KERNEL; j++) begin
                n_rowsum[i] = n_rowsum[i] + SW'(r_p1_prod[i * KERNEL + j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            for (int i = 0; i < KERNEL; i++) begin
                r_p2_rowsum[i] <= n_rowsum[i];
            end
            r_p2_bias <= r_p1_bias;
            r_p2_res  <= r_p1_res;
        end
    end

    // Row sums plus bias, wrapping at 32 bits, go straight into the result queue.
    always_comb begin
        total = r_p2_bias;
        for (int i = 0; i < KERNEL; i++) begin
            total = total + r_p2_rowsum[i];
        end
        o_out_data               = r_p2_res;
        o_out_data.feature_value = total;
    end

    assign o_out_push = r_p2_valid;

    // The filter counter only moves off zero in the middle of a window.
    a_filter_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f != '0 |-> head_window)
        else $error("filter counter running without a window at the queue head");

    // The frame end can only be marked on a position's last filter.
    a_eof_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push && o_out_data.end_of_frame |-> o_out_data.last_of_position)
        else $error("end of frame flagged before the position's last filter");

endmodule

/* rtl/core/conv2d_valid_multi_filter.sv */
// Top level of the streaming valid 2D convolution with a bank of filters.
//
// The block takes a stream of beats on a queue-style input (push/full) and
// delivers results on a queue-style output (empty/pop). A beat is a weight
// load, a bias load, a pixel or a no-op, selected by i_op. Pixels arrive in
// raster order; once the KERNEL x KERNEL window covers a valid position, the
// block emits FILTERS results for it, filter 0 first, each carrying the
// output row and column, the dot product plus bias in Q.15 product scale
// (wrapping at 32 bits), a last-of-position flag on the last filter and an
// end-of-frame flag on the frame's final result. Loads and pixels that do
// not complete a window produce no result. The front end accepts one beat
// per cycle while full is low; the back end computes one filter result per
// cycle while the result queue has room, and each window holds it for all
// FILTERS results, which sets the sustained rate. A position's first
// result passes the front-end stage 1 register, the job queue, the product
// and row-sum stages and the result queue; the others follow one per cycle
// while that queue has room. Coefficient loads are applied in order with
// the pixels, so a load only affects windows that come after it. Both full
// and empty are held high in reset. Write image width and height through
// the configuration port only while the block is idle; the block does not
// enforce this. A write restarts the frame, and out-of-range values are
// saturated to [KERNEL, MAX_WIDTH] and [KERNEL, 1024]. The line store
// needs no clearing pass after reset: every location is rewritten within
// the current frame before it reaches a window that produces a result.
module conv2d_valid_multi_filter #(
    parameter int KERNEL    = 3,
    parameter int FILTERS   = 8,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdmf_pkg::REG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cdmf_pkg::DIM_W-1:0]          i_cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_op,
    input  logic [cdmf_pkg::FIDX_W-1:0]         i_filter_index,
    input  logic [cdmf_pkg::TAP_W-1:0]          i_tap_index,
    input  logic signed [cdmf_pkg::COEF_W-1:0]  i_coefficient,
    input  logic [cdmf_pkg::PIX_W-1:0]          i_pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic [cdmf_pkg::FIDX_W-1:0]         o_out_filter,
    output logic [cdmf_pkg::POS_W-1:0]          o_out_row,
    output logic [cdmf_pkg::POS_W-1:0]          o_out_col,
    output logic signed [cdmf_pkg::COEF_W-1:0]  o_feature_value,
    output logic                                o_last_of_position,
    output logic                                o_end_of_frame
);

    localparam int TAPS   = KERNEL * KERNEL;
    localparam int WIN_W  = TAPS * cdmf_pkg::PIX_W;
    localparam int QDEPTH = cdmf_pkg::MID_DEPTH;
    localparam int ODEPTH = cdmf_pkg::OUT_DEPTH;
    localparam int JOB_W  = $bits(cdmf_pkg::t_job_ctl) + cdmf_pkg::COEF_W + WIN_W;
    localparam int RES_W  = $bits(cdmf_pkg::t_result);

    // Front end to job queue.
    logic                           fq_push;
    cdmf_pkg::t_job_ctl             fq_ctl;
    logic [cdmf_pkg::COEF_W-1:0]    fq_coef;
    logic [WIN_W-1:0]               fq_window;
    logic [$clog2(QDEPTH+1)-1:0]    q_count;

    // Job queue to back end.
    logic [JOB_W-1:0]               q_rdata;
    logic                           q_empty;
    logic                           q_pop;
    cdmf_pkg::t_job_ctl             q_ctl;
    logic [cdmf_pkg::COEF_W-1:0]    q_coef;
    logic [WIN_W-1:0]               q_window;

    // Back end to result queue.
    logic                           out_push;
    cdmf_pkg::t_result              out_wdata;
    cdmf_pkg::t_result              out_rdata;
    logic [RES_W-1:0]               out_rbits;
    logic [$clog2(ODEPTH+1)-1:0]    out_count;
    logic                           out_empty;
    logic                           out_pop;

    cdmf_front #(
        .KERNEL    (KERNEL),
        .FILTERS   (FILTERS),
        .MAX_WIDTH (MAX_WIDTH),
        .QDEPTH    (QDEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .o_full         (full),
        .i_op           (i_op),
        .i_filter_index (i_filter_index),
        .i_tap_index    (i_tap_index),
        .i_coefficient  (i_coefficient),
        .i_pixel        (i_pixel),
        .i_q_count      (q_count),
        .o_q_push       (fq_push),
        .o_q_ctl        (fq_ctl),
        .o_q_coef       (fq_coef),
        .o_q_window     (fq_window)
    );

    // The job queue lets the front keep taking pixels while the back end
    // works through the filters of an earlier window.
    cdmf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QDEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_wdata ({fq_ctl, fq_coef, fq_window}),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {q_ctl, q_coef, q_window} = q_rdata;

    cdmf_back #(
        .KERNEL  (KERNEL),
        .FILTERS (FILTERS),
        .ODEPTH  (ODEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_ctl     (q_ctl),
        .i_q_coef    (q_coef),
        .i_q_window  (q_window),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    // The result queue holds finished beats until the consumer pops them;
    // the back end only issues a filter when a slot is sure to be free.
    cdmf_queue #(
        .WIDTH (RES_W),
        .DEPTH (ODEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wdata),
        .i_pop   (out_pop),
        .o_rdata (out_rbits),
        .o_empty (out_empty),
        .o_count (out_count)
    );

    // The output side reads as empty during reset so no pop is taken there.
    assign out_rdata          = out_rbits;
    assign empty              = out_empty || !i_rst_n;
    assign out_pop            = pop && !empty;
    assign o_out_filter       = out_rdata.out_filter;
    assign o_out_row          = out_rdata.out_row;
    assign o_out_col          = out_rdata.out_col;
    assign o_feature_value    = out_rdata.feature_value;
    assign o_last_of_position = out_rdata.last_of_position;
    assign o_end_of_frame     = out_rdata.end_of_frame;

endmodule
